### rtl/rci_pkg.sv
// ----------------------------------------------------------------------------
// rci_pkg: shared types and constants of the ray / circle intersection unit
// Fixed-point formats, beat structs, status codes and register indexes.
// ----------------------------------------------------------------------------
package rci_pkg;

	// Coordinate format: signed Q(CW-FB).FB
	localparam int CW = 32;
	localparam int FB = 16;

	// Start minus centre, its products and their sums
	localparam int KW = CW + 1;
	localparam int PW = 2 * KW;
	localparam int XW = PW + 1;

	// Quadratic terms after the floor shift; they never reach the clamp bound
	localparam int LW = XW - FB;
	localparam int MW = LW - 1;
	localparam int HW = MW / 2;

	// Discriminant, square root and its remainder
	localparam int DW  = 2 * MW + 2;
	localparam int RN  = DW / 2;
	localparam int SMW = RN + 3;

	// Root numerator, distance and divider dividend
	localparam int NW     = RN + 1;
	localparam int DIST_W = 31;
	localparam int QN     = DIST_W;
	localparam int AW     = MW + QN + 1;

	// Hit point product and sum
	localparam int HPW = CW + DIST_W;
	localparam int SW  = HPW + 2 - FB;

	// Configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;
	localparam logic [CFG_IW-1:0] REG_CENTER_X  = 3'd0;
	localparam logic [CFG_IW-1:0] REG_CENTER_Y  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_RADIUS    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_TOLERANCE = 3'd3;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_PARALLEL  = 3'd1,
		ST_NEGATIVE  = 3'd2,
		ST_TANGENT   = 3'd3,
		ST_INTERSECT = 3'd4
	} status_t;

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] dir_x;
		logic signed [CW-1:0] dir_y;
	} ray_in_t;

	typedef struct packed {
		status_t              status;
		logic [DIST_W-1:0]    hit_distance;
		logic signed [CW-1:0] hit_x;
		logic signed [CW-1:0] hit_y;
	} ray_out_t;

	typedef struct packed {
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic [30:0]          radius;
		logic [30:0]          tolerance;
	} cfg_t;

	// Per-ray context carried alongside the arithmetic
	typedef struct packed {
		status_t              status;
		logic                 done;
		logic                 tang;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [LW-1:0] l1;
		logic [MW-1:0]        l2;
	} ctx_t;

endpackage

### rtl/rci_front.sv
// ----------------------------------------------------------------------------
// rci_front: quadratic terms and discriminant
// Five stages: offset, products, floor-shifted terms, split squares, disc.
// ----------------------------------------------------------------------------
module rci_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld,
	input  rci_pkg::ray_in_t       ray,
	input  rci_pkg::cfg_t          cfg,
	output logic                   vld_o,
	output rci_pkg::ctx_t          ctx_o,
	output logic [rci_pkg::DW-1:0] rad_o
);

	localparam int KW = rci_pkg::KW;
	localparam int PW = rci_pkg::PW;
	localparam int XW = rci_pkg::XW;
	localparam int LW = rci_pkg::LW;
	localparam int MW = rci_pkg::MW;
	localparam int HW = rci_pkg::HW;
	localparam int DW = rci_pkg::DW;
	localparam int FB = rci_pkg::FB;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	rci_pkg::ray_in_t ray_s1, ray_s2, ray_s3, ray_s4;

	logic signed [KW-1:0] kx_s1, ky_s1;
	logic signed [PW-1:0] kxx_s2, kyy_s2, kxd_s2, kyd_s2, dxx_s2, dyy_s2;
	logic [61:0]          rr_s2;
	logic signed [XW-1:0] l0x, l1x, l2x;
	logic signed [LW-1:0] l0_s3, l1_s3, l1_s4;
	logic [MW-1:0]        l2_s3, l2_s4;
	logic [LW-1:0]        m0f, m1f;
	logic [MW-1:0]        m0, m1;
	logic                 s0_s4;
	logic [2*HW-1:0]      p1hh_s4, p1hl_s4, p1ll_s4;
	logic [2*HW-1:0]      p0hh_s4, p0hl_s4, p0lh_s4, p0ll_s4;
	logic [DW-1:0]        sq1, pr, disc;
	rci_pkg::ctx_t        ctx_nx;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Offset from the centre, then the seven products
	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray;
			kx_s1  <= KW'(ray.start_x) - KW'(cfg.center_x);
			ky_s1  <= KW'(ray.start_y) - KW'(cfg.center_y);
			ray_s2 <= ray_s1;
			kxx_s2 <= kx_s1 * kx_s1;
			kyy_s2 <= ky_s1 * ky_s1;
			kxd_s2 <= kx_s1 * KW'(ray_s1.dir_x);
			kyd_s2 <= ky_s1 * KW'(ray_s1.dir_y);
			dxx_s2 <= ray_s1.dir_x * ray_s1.dir_x;
			dyy_s2 <= ray_s1.dir_y * ray_s1.dir_y;
			rr_s2  <= cfg.radius * cfg.radius;
		end
	end

	// Sum the products; arithmetic shift is the floor to Q.FB
	assign l0x = XW'(kxx_s2) + XW'(kyy_s2) - XW'(rr_s2);
	assign l1x = XW'(kxd_s2) + XW'(kyd_s2);
	assign l2x = XW'(dxx_s2) + XW'(dyy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s3 <= ray_s2;
			l0_s3  <= LW'(l0x >>> FB);
			l1_s3  <= LW'(l1x >>> FB);
			l2_s3  <= MW'(l2x >>> FB);
		end
	end

	// Split magnitudes into halves for the squares
	assign m0f = l0_s3[LW-1] ? (~l0_s3 + LW'(1)) : l0_s3;
	assign m1f = l1_s3[LW-1] ? (~l1_s3 + LW'(1)) : l1_s3;
	assign m0  = m0f[MW-1:0];
	assign m1  = m1f[MW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s4  <= ray_s3;
			l1_s4   <= l1_s3;
			l2_s4   <= l2_s3;
			s0_s4   <= l0_s3[LW-1];
			p1hh_s4 <= m1[MW-1:HW] * m1[MW-1:HW];
			p1hl_s4 <= m1[MW-1:HW] * m1[HW-1:0];
			p1ll_s4 <= m1[HW-1:0] * m1[HW-1:0];
			p0hh_s4 <= m0[MW-1:HW] * l2_s3[MW-1:HW];
			p0hl_s4 <= m0[MW-1:HW] * l2_s3[HW-1:0];
			p0lh_s4 <= m0[HW-1:0] * l2_s3[MW-1:HW];
			p0ll_s4 <= m0[HW-1:0] * l2_s3[HW-1:0];
		end
	end

	// Recombine partials and form the discriminant
	assign sq1  = (DW'(p1hh_s4) << (2 * HW)) + (DW'(p1hl_s4) << (HW + 1)) + DW'(p1ll_s4);
	assign pr   = (DW'(p0hh_s4) << (2 * HW)) + ((DW'(p0hl_s4) + DW'(p0lh_s4)) << HW)
		+ DW'(p0ll_s4);
	assign disc = s0_s4 ? (sq1 + pr) : (sq1 - pr);

	// Early verdicts: no real root, then too short a direction
	always_comb begin
		ctx_nx      = '0;
		ctx_nx.sx   = ray_s4.start_x;
		ctx_nx.sy   = ray_s4.start_y;
		ctx_nx.dx   = ray_s4.dir_x;
		ctx_nx.dy   = ray_s4.dir_y;
		ctx_nx.l1   = l1_s4;
		ctx_nx.l2   = l2_s4;
		ctx_nx.tang = disc[DW-2:FB] <= (DW-1-FB)'(cfg.tolerance);
		priority if (disc[DW-1]) begin
			ctx_nx.status = rci_pkg::ST_NONE;
			ctx_nx.done   = 1'b1;
		end else if (l2_s4 <= MW'(cfg.tolerance)) begin
			ctx_nx.status = rci_pkg::ST_PARALLEL;
			ctx_nx.done   = 1'b1;
		end else begin
			ctx_nx.status = rci_pkg::ST_INTERSECT;
			ctx_nx.done   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_o <= ctx_nx;
			rad_o <= disc;
		end
	end

	assign vld_o = v_s5;

endmodule

### rtl/rci_sqrt.sv
// ----------------------------------------------------------------------------
// rci_sqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per stage.
// ----------------------------------------------------------------------------
module rci_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld,
	input  rci_pkg::ctx_t          ctx,
	input  logic [rci_pkg::DW-1:0] rad,
	output logic                   vld_o,
	output rci_pkg::ctx_t          ctx_o,
	output logic [rci_pkg::RN-1:0] root_o
);

	localparam int DW  = rci_pkg::DW;
	localparam int RN  = rci_pkg::RN;
	localparam int SMW = rci_pkg::SMW;

	logic          vld_s  [RN];
	rci_pkg::ctx_t ctx_s  [RN];
	logic [DW-1:0] rad_s  [RN];
	logic [SMW-1:0] rem_s [RN];
	logic [RN-1:0] root_s [RN];

	for (genvar j = 0; j < RN; j++) begin : g_stage
		logic           v_in;
		rci_pkg::ctx_t  c_in;
		logic [DW-1:0]  r_in;
		logic [SMW-1:0] m_in, m_sh, trial;
		logic [RN-1:0]  q_in;
		logic           ge;

		if (j == 0) begin : g_first
			assign v_in = vld;
			assign c_in = ctx;
			assign r_in = rad;
			assign m_in = '0;
			assign q_in = '0;
		end else begin : g_next
			assign v_in = vld_s[j-1];
			assign c_in = ctx_s[j-1];
			assign r_in = rad_s[j-1];
			assign m_in = rem_s[j-1];
			assign q_in = root_s[j-1];
		end

		// Bring down two radicand bits and try the next root bit
		assign m_sh  = {m_in[SMW-3:0], r_in[DW-1 -: 2]};
		assign trial = {1'b0, q_in, 2'b01};
		assign ge    = m_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[j]  <= c_in;
				rad_s[j]  <= r_in << 2;
				rem_s[j]  <= ge ? (m_sh - trial) : m_sh;
				root_s[j] <= {q_in[RN-2:0], ge};
			end
		end
	end

	assign vld_o  = vld_s[RN-1];
	assign ctx_o  = ctx_s[RN-1];
	assign root_o = root_s[RN-1];

endmodule

### rtl/rci_div.sv
// ----------------------------------------------------------------------------
// rci_div: root choice and pipelined distance divider
// One stage picks the nearest positive root, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rci_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld,
	input  rci_pkg::ctx_t              ctx,
	input  logic [rci_pkg::RN-1:0]     sq,
	output logic                       vld_o,
	output rci_pkg::ctx_t              ctx_o,
	output logic [rci_pkg::DIST_W-1:0] dist_o
);

	localparam int LW = rci_pkg::LW;
	localparam int MW = rci_pkg::MW;
	localparam int NW = rci_pkg::NW;
	localparam int AW = rci_pkg::AW;
	localparam int QN = rci_pkg::QN;
	localparam int FB = rci_pkg::FB;

	logic [LW-1:0] m1f;
	logic [MW-1:0] m1;
	logic [NW-1:0] num;
	logic          neg_root;
	rci_pkg::ctx_t ctx_nx;

	logic          v_s0;
	rci_pkg::ctx_t ctx_s0;
	logic [AW-1:0] a_s0;
	logic [MW-1:0] den_s0;
	logic          sat_s0;

	logic          vld_s [QN];
	rci_pkg::ctx_t ctx_s [QN];
	logic [AW-1:0] a_s   [QN];
	logic [MW-1:0] den_s [QN];
	logic          sat_s [QN];
	logic [QN-1:0] q_s   [QN];

	// Pick the near root, else the far one, else report behind the start
	assign m1f = ctx.l1[LW-1] ? (~ctx.l1 + LW'(1)) : ctx.l1;
	assign m1  = m1f[MW-1:0];

	always_comb begin
		neg_root = 1'b0;
		num      = '0;
		priority if (ctx.l1[LW-1]) begin
			if (NW'(m1) > NW'(sq)) begin
				num = NW'(m1) - NW'(sq);
			end else begin
				num = NW'(sq) + NW'(m1);
			end
		end else if (NW'(sq) > NW'(m1)) begin
			num = NW'(sq) - NW'(m1);
		end else begin
			neg_root = 1'b1;
		end
	end

	always_comb begin
		ctx_nx = ctx;
		if (!ctx.done) begin
			if (neg_root) begin
				ctx_nx.status = rci_pkg::ST_NEGATIVE;
				ctx_nx.done   = 1'b1;
			end else begin
				ctx_nx.status = ctx.tang ? rci_pkg::ST_TANGENT : rci_pkg::ST_INTERSECT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= vld;
		end
	end

	// Flag a quotient that will not fit the distance field
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s0 <= ctx_nx;
			a_s0   <= AW'(num) << FB;
			den_s0 <= ctx.l2;
			sat_s0 <= (AW'(ctx.l2) << QN) <= (AW'(num) << FB);
		end
	end

	for (genvar k = 0; k < QN; k++) begin : g_stage
		logic           v_in;
		rci_pkg::ctx_t  c_in;
		logic [AW-1:0]  a_in, b;
		logic [MW-1:0]  d_in;
		logic           s_in;
		logic [QN-1:0]  q_in;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_in = v_s0;
			assign c_in = ctx_s0;
			assign a_in = a_s0;
			assign d_in = den_s0;
			assign s_in = sat_s0;
			assign q_in = '0;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign c_in = ctx_s[k-1];
			assign a_in = a_s[k-1];
			assign d_in = den_s[k-1];
			assign s_in = sat_s[k-1];
			assign q_in = q_s[k-1];
		end

		// Subtract the shifted divisor where it fits
		assign b  = AW'(d_in) << (QN - 1 - k);
		assign ge = b <= a_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k] <= c_in;
				a_s[k]   <= ge ? (a_in - b) : a_in;
				den_s[k] <= d_in;
				sat_s[k] <= s_in;
				q_s[k]   <= {q_in[QN-2:0], ge};
			end
		end
	end

	assign vld_o  = vld_s[QN-1];
	assign ctx_o  = ctx_s[QN-1];
	assign dist_o = sat_s[QN-1] ? '1 : q_s[QN-1];

endmodule

### rtl/rci_hit.sv
// ----------------------------------------------------------------------------
// rci_hit: hit point and result beat
// Scales the direction by the distance, then adds the start with saturation.
// ----------------------------------------------------------------------------
module rci_hit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld,
	input  rci_pkg::ctx_t              ctx,
	input  logic [rci_pkg::DIST_W-1:0] dist_val,
	output logic                       vld_o,
	output rci_pkg::ray_out_t          res_o
);

	localparam int CW  = rci_pkg::CW;
	localparam int FB  = rci_pkg::FB;
	localparam int HPW = rci_pkg::HPW;
	localparam int SW  = rci_pkg::SW;
	localparam logic [HPW:0] RND = (HPW+1)'((1 << FB) - 1);

	logic [rci_pkg::DIST_W-1:0] t_eff;
	logic [CW-1:0]              ax, ay;

	logic                       v_s1;
	rci_pkg::status_t           st_s1;
	logic                       done_s1, nx_s1, ny_s1;
	logic [rci_pkg::DIST_W-1:0] t_s1;
	logic signed [CW-1:0]       sx_s1, sy_s1;
	logic [HPW-1:0]             mx_s1, my_s1;

	logic [HPW:0]               adjx, adjy;
	logic [HPW-FB:0]            qx, qy;
	logic signed [SW-1:0]       sumx, sumy;
	rci_pkg::ray_out_t          res_nx;

	// Zero distance for rays without a hit keeps the products harmless
	assign t_eff = ctx.done ? '0 : dist_val;
	assign ax    = ctx.dx[CW-1] ? (~ctx.dx + CW'(1)) : ctx.dx;
	assign ay    = ctx.dy[CW-1] ? (~ctx.dy + CW'(1)) : ctx.dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			vld_o <= 1'b0;
		end else if (en) begin
			v_s1  <= vld;
			vld_o <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1   <= ctx.status;
			done_s1 <= ctx.done;
			nx_s1   <= ctx.dx[CW-1];
			ny_s1   <= ctx.dy[CW-1];
			t_s1    <= t_eff;
			sx_s1   <= ctx.sx;
			sy_s1   <= ctx.sy;
			mx_s1   <= ax * t_eff;
			my_s1   <= ay * t_eff;
		end
	end

	// Floor shift of the signed product, then add the start
	assign adjx = {1'b0, mx_s1} + (nx_s1 ? RND : '0);
	assign adjy = {1'b0, my_s1} + (ny_s1 ? RND : '0);
	assign qx   = adjx[HPW:FB];
	assign qy   = adjy[HPW:FB];
	assign sumx = SW'(sx_s1) + (nx_s1 ? -SW'(qx) : SW'(qx));
	assign sumy = SW'(sy_s1) + (ny_s1 ? -SW'(qy) : SW'(qy));

	function automatic logic [CW-1:0] clamp_coord(input logic [SW-1:0] v);
		logic [SW-CW:0] top;
		top = v[SW-1:CW-1];
		if (&top || ~|top) begin
			return v[CW-1:0];
		end
		return v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	always_comb begin
		res_nx        = '0;
		res_nx.status = st_s1;
		if (!done_s1) begin
			res_nx.hit_distance = t_s1;
			res_nx.hit_x        = clamp_coord(sumx);
			res_nx.hit_y        = clamp_coord(sumy);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_o <= res_nx;
		end
	end

endmodule

### rtl/ray_circle_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_circle_intersect_unit: 2D ray against a configured circle
// Reports none, parallel, negative, tangent or intersect with distance and point.
// ----------------------------------------------------------------------------
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_stall  | in_data  : start_x, start_y, dir_x, dir_y
//   out      | out_valid / out_stall| out_data : status, hit_distance, hit_x, hit_y
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// One ray per cycle while no result beat is held; the path runs through the terms
// and discriminant, the square root (one root bit per stage), root choice and the
// divider (one quotient bit per stage) and the hit point.
// Reset clears all valid bits and loads the register reset values.
// A stalled result beat freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module ray_circle_intersect_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rci_pkg::ray_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rci_pkg::ray_out_t             out_data,
	input  logic                          cfg_we,
	input  logic [rci_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [rci_pkg::CFG_DW-1:0]    cfg_data
);

	rci_pkg::cfg_t cfg_q;
	logic          en;

	logic                       f_vld, s_vld, d_vld;
	rci_pkg::ctx_t              f_ctx, s_ctx, d_ctx;
	logic [rci_pkg::DW-1:0]     f_rad;
	logic [rci_pkg::RN-1:0]     s_root;
	logic [rci_pkg::DIST_W-1:0] d_dist;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x  <= '0;
			cfg_q.center_y  <= '0;
			cfg_q.radius    <= 31'd65536;
			cfg_q.tolerance <= 31'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rci_pkg::REG_CENTER_X:  cfg_q.center_x  <= cfg_data[rci_pkg::CW-1:0];
				rci_pkg::REG_CENTER_Y:  cfg_q.center_y  <= cfg_data[rci_pkg::CW-1:0];
				rci_pkg::REG_RADIUS:    cfg_q.radius    <= cfg_data[30:0];
				rci_pkg::REG_TOLERANCE: cfg_q.tolerance <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Advance the pipeline unless a result beat is held
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	rci_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (in_valid),
		.ray    (in_data),
		.cfg    (cfg_q),
		.vld_o  (f_vld),
		.ctx_o  (f_ctx),
		.rad_o  (f_rad)
	);

	rci_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (f_vld),
		.ctx    (f_ctx),
		.rad    (f_rad),
		.vld_o  (s_vld),
		.ctx_o  (s_ctx),
		.root_o (s_root)
	);

	rci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (s_vld),
		.ctx    (s_ctx),
		.sq     (s_root),
		.vld_o  (d_vld),
		.ctx_o  (d_ctx),
		.dist_o (d_dist)
	);

	rci_hit u_hit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (d_vld),
		.ctx      (d_ctx),
		.dist_val (d_dist),
		.vld_o    (out_valid),
		.res_o    (out_data)
	);

	// A miss carries no distance
	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == rci_pkg::ST_NONE
			|| out_data.status == rci_pkg::ST_PARALLEL
			|| out_data.status == rci_pkg::ST_NEGATIVE)
		|-> out_data.hit_distance == '0)
		else $error("miss with nonzero distance");

	// A miss carries no hit point
	a_miss_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == rci_pkg::ST_NONE
			|| out_data.status == rci_pkg::ST_PARALLEL
			|| out_data.status == rci_pkg::ST_NEGATIVE)
		|-> out_data.hit_x == '0 && out_data.hit_y == '0)
		else $error("miss with nonzero hit point");

	// A held result freezes the front of the pipeline
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(f_vld) && $stable(s_vld) && $stable(d_vld))
		else $error("pipeline moved under a held result");

endmodule
